// ----- design/tun_pkg.sv -----
// shared types and constants for the triangle unit normal pipeline
// no dependencies; used by every module of the block
package tun_pkg;

	// bits of a scaled cross magnitude, largest one has bit 30 set unless all are zero
	localparam int MAG_BITS = 31;
	// sum of three squared magnitudes
	localparam int SUM_BITS = 64;
	// integer square root of the sum
	localparam int ROOT_BITS = 32;
	// one stage per root bit
	localparam int ISQRT_STEPS = 32;

	// control that travels with each request through the pipeline
	typedef struct packed {
		logic       valid;
		logic       deg;
		logic [2:0] neg;
	} tun_ctl_t;

endpackage

// ----- design/tun_cross.sv -----
// edge vectors, exact cross product, magnitude and block scaling to 31 bits
// depends on tun_pkg
module tun_cross #(
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [9*COORD_BITS-1:0]               coords,
	output tun_pkg::tun_ctl_t                     ctl,
	output logic [2:0][tun_pkg::MAG_BITS-1:0]     mag
);

	localparam int EW  = COORD_BITS + 1;
	localparam int PW  = 2 * EW;
	localparam int CW  = PW + 1;
	localparam int BLW = $clog2(CW + 1);
	localparam int MB  = tun_pkg::MAG_BITS;

	logic [COORD_BITS-1:0] v0 [3];
	logic [COORD_BITS-1:0] v1 [3];
	logic [COORD_BITS-1:0] v2 [3];

	logic signed [EW-1:0] e_s1 [3];
	logic signed [EW-1:0] f_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [CW-1:0] c_s3 [3];
	logic [CW-1:0]        mag_s4 [3];
	logic [2:0]           neg_s4;
	logic [CW-1:0]        mag_s5 [3];
	logic [2:0]           neg_s5;
	logic                 deg_s5;
	logic [BLW-1:0]       bl_s5;
	logic [MB-1:0]        m_s6 [3];
	logic [2:0]           neg_s6;
	logic                 deg_s6;
	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic [CW-1:0]        or_mag;
	logic [BLW-1:0]       blen;
	logic [CW+MB-1:0]     shifted [3];

	// unpack vertices
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			v0[k] = coords[k*COORD_BITS +: COORD_BITS];
			v1[k] = coords[(3+k)*COORD_BITS +: COORD_BITS];
			v2[k] = coords[(6+k)*COORD_BITS +: COORD_BITS];
		end
	end

	// bit length of the largest magnitude
	always_comb begin
		or_mag = mag_s4[0] | mag_s4[1] | mag_s4[2];
		blen = '0;
		for (int i = 0; i < CW; i++) begin
			if (or_mag[i]) blen = BLW'(i + 1);
		end
	end

	// scale so the largest magnitude has bit length 31
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			shifted[k] = {mag_s5[k], {MB{1'b0}}} >> bl_s5;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e_s1[k] <= $signed({v1[k][COORD_BITS-1], v1[k]})
					- $signed({v0[k][COORD_BITS-1], v0[k]});
				f_s1[k] <= $signed({v2[k][COORD_BITS-1], v2[k]})
					- $signed({v0[k][COORD_BITS-1], v0[k]});
			end
			p_s2[0] <= e_s1[1] * f_s1[2];
			p_s2[1] <= e_s1[2] * f_s1[1];
			p_s2[2] <= e_s1[2] * f_s1[0];
			p_s2[3] <= e_s1[0] * f_s1[2];
			p_s2[4] <= e_s1[0] * f_s1[1];
			p_s2[5] <= e_s1[1] * f_s1[0];
			for (int k = 0; k < 3; k++) begin
				c_s3[k] <= $signed({p_s2[2*k][PW-1], p_s2[2*k]})
					- $signed({p_s2[2*k+1][PW-1], p_s2[2*k+1]});
				mag_s4[k] <= c_s3[k][CW-1] ? CW'(-c_s3[k]) : CW'(c_s3[k]);
				neg_s4[k] <= c_s3[k][CW-1];
				mag_s5[k] <= mag_s4[k];
				m_s6[k]   <= shifted[k][MB-1:0];
			end
			neg_s5 <= neg_s4;
			deg_s5 <= (or_mag == '0);
			bl_s5  <= blen;
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;
		end
	end

	assign ctl = '{valid: valid_s6, deg: deg_s6, neg: neg_s6};
	assign mag[0] = m_s6[0];
	assign mag[1] = m_s6[1];
	assign mag[2] = m_s6[2];

endmodule

// ----- design/tun_isqrt.sv -----
// sum of squares and a pipelined integer square root, one root bit per stage
// depends on tun_pkg
module tun_isqrt (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  tun_pkg::tun_ctl_t                     ctl_in,
	input  logic [2:0][tun_pkg::MAG_BITS-1:0]     mag_in,
	output tun_pkg::tun_ctl_t                     ctl_out,
	output logic [2:0][tun_pkg::MAG_BITS-1:0]     mag_out,
	output logic [tun_pkg::ROOT_BITS-1:0]         root
);

	localparam int MB = tun_pkg::MAG_BITS;
	localparam int SW = tun_pkg::SUM_BITS;
	localparam int NS = tun_pkg::ISQRT_STEPS;

	logic [2*MB-1:0]         sq_s1 [3];
	tun_pkg::tun_ctl_t       ctl_s1;
	logic [2:0][MB-1:0]      mag_s1;

	logic [SW-1:0]           rem_s [NS+1];
	logic [SW-1:0]           res_s [NS+1];
	tun_pkg::tun_ctl_t       ctl_s [NS+1];
	logic [2:0][MB-1:0]      mag_s [NS+1];

	// squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= mag_in[k] * mag_in[k];
			end
			mag_s1 <= mag_in;
		end
	end

	// sum of squares, start of root iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
			res_s[0] <= '0;
			mag_s[0] <= mag_s1;
		end
	end

	// one compare and subtract per stage
	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NS - 1 - k));
		logic [SW-1:0] trial;

		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[k+1] <= mag_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign ctl_out = ctl_s[NS];
	assign mag_out = mag_s[NS];
	assign root    = res_s[NS][tun_pkg::ROOT_BITS-1:0];

endmodule

// ----- design/tun_div.sv -----
// rounded division of each magnitude by the length, one quotient bit per stage,
// then sign and output register; depends on tun_pkg
module tun_div #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  tun_pkg::tun_ctl_t                      ctl_in,
	input  logic [2:0][tun_pkg::MAG_BITS-1:0]      mag_in,
	input  logic [tun_pkg::ROOT_BITS-1:0]          root,
	output logic                                   out_valid,
	output logic                                   out_deg,
	output logic [2:0][NORMAL_FRAC_BITS+1:0]       normal
);

	localparam int MB = tun_pkg::MAG_BITS;
	localparam int Q  = NORMAL_FRAC_BITS + 1;
	localparam int NW = MB + Q + 1;
	localparam int DW = tun_pkg::ROOT_BITS + 1;
	localparam int RW = DW + 1;
	localparam int OW = NORMAL_FRAC_BITS + 2;

	logic [RW-1:0]      rem_s [Q+1][3];
	logic [Q-1:0]       low_s [Q+1][3];
	logic [Q-1:0]       quo_s [Q+1][3];
	logic [DW-1:0]      d_s   [Q+1];
	tun_pkg::tun_ctl_t  ctl_s [Q+1];
	logic [NW-1:0]      num [3];

	logic [OW-1:0]      n_out_s [3];
	logic               deg_out_s;
	logic               valid_out_s;

	// numerator 2*m*2^F + L over denominator 2*L
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num[l] = (NW'(mag_in[l]) << Q) + NW'(root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= {root, 1'b0};
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= RW'(num[l] >> Q);
				low_s[0][l] <= num[l][Q-1:0];
				quo_s[0][l] <= '0;
			end
		end
	end

	// restoring division steps
	for (genvar j = 0; j < Q; j++) begin : g_step
		logic [RW-1:0] t [3];

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				t[l] = {rem_s[j][l][RW-2:0], low_s[j][l][Q-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j+1] <= d_s[j];
				for (int l = 0; l < 3; l++) begin
					low_s[j+1][l] <= low_s[j][l] << 1;
					if (t[l] >= RW'(d_s[j])) begin
						rem_s[j+1][l] <= t[l] - RW'(d_s[j]);
						quo_s[j+1][l] <= {quo_s[j][l][Q-2:0], 1'b1};
					end else begin
						rem_s[j+1][l] <= t[l];
						quo_s[j+1][l] <= {quo_s[j][l][Q-2:0], 1'b0};
					end
				end
			end
		end
	end

	// sign and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_s <= 1'b0;
		end else if (en) begin
			valid_out_s <= ctl_s[Q].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_out_s <= ctl_s[Q].deg;
			for (int l = 0; l < 3; l++) begin
				if (ctl_s[Q].deg) begin
					n_out_s[l] <= '0;
				end else if (ctl_s[Q].neg[l]) begin
					n_out_s[l] <= -OW'(quo_s[Q][l]);
				end else begin
					n_out_s[l] <= OW'(quo_s[Q][l]);
				end
			end
		end
	end

	assign out_valid = valid_out_s;
	assign out_deg   = deg_out_s;
	assign normal[0] = n_out_s[0];
	assign normal[1] = n_out_s[1];
	assign normal[2] = n_out_s[2];

endmodule

// ----- design/triangle_unit_normal_core.sv -----
// one request per cycle while the output register is empty or taken
// stages: 6 cross and scaling, 34 squares/sum/root (one root bit per stage),
// NORMAL_FRAC_BITS + 3 division and output; the root and divider chains set the depth
// the whole pipeline advances when the output register is empty or taken
// reset clears all valid bits; data registers are not reset
module triangle_unit_normal_core #(
	parameter int COORD_BITS       = 24,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z, zero padded
	input  logic [((9*COORD_BITS+7)/8)*8-1:0]        s_tdata,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// normal_x normal_y normal_z, zero padded
	output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic [0:0]                               m_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready
);

	localparam int OW  = NORMAL_FRAC_BITS + 2;
	localparam int ODW = ((3*OW+7)/8)*8;

	logic                                   en;
	tun_pkg::tun_ctl_t                      ctl_a, ctl_b;
	logic [2:0][tun_pkg::MAG_BITS-1:0]      mag_a, mag_b;
	logic [tun_pkg::ROOT_BITS-1:0]          root;
	logic                                   deg;
	logic [2:0][OW-1:0]                     normal;

	// global advance
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	tun_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.coords   (s_tdata[9*COORD_BITS-1:0]),
		.ctl      (ctl_a),
		.mag      (mag_a)
	);

	tun_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_a),
		.mag_in  (mag_a),
		.ctl_out (ctl_b),
		.mag_out (mag_b),
		.root    (root)
	);

	tun_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ctl_b),
		.mag_in    (mag_b),
		.root      (root),
		.out_valid (m_tvalid),
		.out_deg   (deg),
		.normal    (normal)
	);

	// output packing
	assign m_tdata    = ODW'({normal[2], normal[1], normal[0]});
	assign m_tuser[0] = deg;

	// degenerate result carries a zero normal
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> normal[0] == '0 && normal[1] == '0 && normal[2] == '0)
		else $error("degenerate result with nonzero normal");

	// components do not exceed one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(normal[0]) <= $signed(OW'(1) << NORMAL_FRAC_BITS)
			&& $signed(normal[1]) <= $signed(OW'(1) << NORMAL_FRAC_BITS)
			&& $signed(normal[2]) <= $signed(OW'(1) << NORMAL_FRAC_BITS))
		else $error("normal component above one");

	// input is held off only by a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back pressure");

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for triangle_unit_normal_core: exact cross product and unit normal
// depends on design/triangle_unit_normal_core.sv; all prediction is done locally
`timescale 1ns / 100ps

module testbench;

	localparam int CB = 24;
	localparam int NF = 14;
	localparam int OB = NF + 2;
	localparam int IN_W = ((9*CB+7)/8)*8;
	localparam int OUT_W = ((3*OB+7)/8)*8;
	localparam int LATENCY = NF + 43;
	localparam int WATCHDOG = 20000;
	localparam logic [CB-1:0] CMAX = 24'h7fffff;
	localparam logic [CB-1:0] CMIN = 24'h800000;

	typedef struct packed {
		logic [OB-1:0] nx, ny, nz;
		logic          deg;
	} normal_t;

	typedef struct {
		logic [CB-1:0] v[9];
		logic          has_ref;
		normal_t       ref_out;
	} tri_row_t;

	logic                clk;
	logic                arst_n;
	logic [IN_W-1:0]     s_tdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic [0:0]          m_tuser;
	logic                m_tvalid;
	logic                m_tready;

	normal_t expected_normals[$];
	int      errors;
	int      idle_cycles;
	bit      stim_done;
	bit      hold_long;

	triangle_unit_normal_core #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(NF)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// integer square root, bit by bit
	function automatic logic [63:0] root64(logic [63:0] s);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// unit normal of one triangle
	function automatic normal_t face_normal(logic [CB-1:0] v[9]);
		logic signed [CB:0]    e[3], f[3];
		logic signed [127:0]   c[3];
		logic [127:0]          mag[3];
		logic [63:0]           m[3], sum, len, n;
		logic [2:0]            neg;
		int                    blen;
		normal_t               r;
		for (int k = 0; k < 3; k++) begin
			e[k] = $signed(v[3+k]) - $signed(v[k]);
			f[k] = $signed(v[6+k]) - $signed(v[k]);
		end
		c[0] = e[1]*f[2] - e[2]*f[1];
		c[1] = e[2]*f[0] - e[0]*f[2];
		c[2] = e[0]*f[1] - e[1]*f[0];
		blen = 0;
		for (int k = 0; k < 3; k++) begin
			neg[k] = c[k][127];
			mag[k] = neg[k] ? -c[k] : c[k];
			for (int i = 0; i < 128; i++)
				if (mag[k][i] && i + 1 > blen) blen = i + 1;
		end
		if (blen == 0) begin
			r.nx = '0; r.ny = '0; r.nz = '0; r.deg = 1'b1;
			return r;
		end
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			if (blen <= 31) m[k] = 64'(mag[k] << (31 - blen));
			else m[k] = 64'(mag[k] >> (blen - 31));
			sum = sum + m[k]*m[k];
		end
		len = root64(sum);
		for (int k = 0; k < 3; k++) begin
			n = ((m[k] << (NF + 1)) + len) / (len << 1);
			if (neg[k]) n = -n;
			case (k)
				0: r.nx = n[OB-1:0];
				1: r.ny = n[OB-1:0];
				default: r.nz = n[OB-1:0];
			endcase
		end
		r.deg = 1'b0;
		return r;
	endfunction

	function automatic logic [CB-1:0] rand_coord(int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'($urandom_range(0, 255)) - 24'd128;
			default: return $urandom_range(0, 1) ? CMAX : CMIN;
		endcase
	endfunction

	// send one triangle, with a random gap first
	task automatic send_triangle(logic [CB-1:0] v[9], logic has_ref, normal_t ref_out);
		logic [IN_W-1:0] word;
		normal_t         pred;
		int              gap;
		word = '0;
		for (int k = 0; k < 9; k++) word[k*CB +: CB] = v[k];
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= word;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = face_normal(v);
		if (has_ref && pred != ref_out)
			$error("directed row disagrees with prediction");
		expected_normals.push_back(pred);
	endtask

	// sender
	initial begin
		tri_row_t    rows[$];
		tri_row_t    row;
		logic [CB-1:0] v[9];
		normal_t     zero_n, px, nz;
		int          mode;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		stim_done = 1'b0;
		hold_long = 1'b0;
		zero_n = '{'0, '0, '0, 1'b1};
		px = '{16'd16384, '0, '0, 1'b0};
		nz = '{'0, '0, -16'sd16384, 1'b0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: all zero, coincident extremes, axis-aligned, collinear, extremes, small triangles
		row.v = '{default: '0}; row.has_ref = 1; row.ref_out = zero_n; rows.push_back(row);
		row.v = '{default: CMAX}; rows.push_back(row);
		row.v = '{default: CMIN}; rows.push_back(row);
		row.v = '{0, 0, 0, 0, 1, 0, 0, 0, 1}; row.ref_out = px; rows.push_back(row);
		row.v = '{0, 0, 0, 0, 0, 1, 0, 1, 0}; row.ref_out = px; row.ref_out.nx = -16'sd16384;
		rows.push_back(row);
		row.v = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; row.ref_out = nz; rows.push_back(row);
		row.v = '{0, 0, 0, 1, 1, 1, 2, 2, 2}; row.ref_out = zero_n; rows.push_back(row);
		row.v = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX}; row.has_ref = 0;
		rows.push_back(row);
		row.v = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}; rows.push_back(row);
		row.v = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}; rows.push_back(row);
		row.v = '{0, 0, 0, 1, 0, 0, 0, 24'hffffff, 0}; rows.push_back(row);
		row.v = '{5, 7, 9, 5, 7, 10, 6, 7, 9}; rows.push_back(row);
		row.v = '{0, 0, 0, 3, 4, 0, 24'hfffffc, 3, 0}; rows.push_back(row);
		foreach (rows[i]) send_triangle(rows[i].v, rows[i].has_ref, rows[i].ref_out);

		// receiver holds off for a long stretch while requests keep coming
		hold_long = 1'b1;
		for (int i = 0; i < 100; i++) begin
			foreach (v[k]) v[k] = rand_coord(0);
			send_triangle(v, 0, zero_n);
		end
		hold_long = 1'b0;

		// sender pauses until every result is back
		s_tvalid <= 1'b0;
		while (expected_normals.size() != 0) @(posedge clk);

		// random part
		for (int i = 0; i < 340; i++) begin
			mode = $urandom_range(0, 9);
			for (int k = 0; k < 9; k++)
				v[k] = rand_coord(mode < 6 ? 0 : (mode < 9 ? 1 : $urandom_range(0, 2)));
			if ($urandom_range(0, 15) == 0) begin
				// collinear or coincident
				for (int k = 0; k < 3; k++) v[6+k] = v[3+k] + v[3+k] - v[k];
			end
			send_triangle(v, 0, zero_n);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver with random stalls
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				while (hold_long) begin
					m_tready <= 1'b1;
					@(posedge clk);
				end
			end
			stall = ($urandom_range(0, 9) < 6) ? 0 :
				(($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3));
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// result checking
	always @(posedge clk) begin
		normal_t exp_n;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_normals.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				exp_n = expected_normals.pop_front();
				if (m_tdata[0 +: OB] !== exp_n.nx) begin
					$error("normal_x expected %h actual %h", exp_n.nx, m_tdata[0 +: OB]);
					errors++;
				end
				if (m_tdata[OB +: OB] !== exp_n.ny) begin
					$error("normal_y expected %h actual %h", exp_n.ny, m_tdata[OB +: OB]);
					errors++;
				end
				if (m_tdata[2*OB +: OB] !== exp_n.nz) begin
					$error("normal_z expected %h actual %h", exp_n.nz, m_tdata[2*OB +: OB]);
					errors++;
				end
				if (m_tuser[0] !== exp_n.deg) begin
					$error("degenerate expected %b actual %b", exp_n.deg, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	// end of run
	initial begin
		wait (stim_done);
		while (expected_normals.size() != 0 && idle_cycles < WATCHDOG) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0 && expected_normals.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// timeout before stimulus completes
	initial begin
		wait (idle_cycles >= WATCHDOG && !stim_done);
		$display("tb: failure");
		$finish;
	end

endmodule
